@@ src/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the RTL; compiled out with NO_ASSERTIONS.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

@@ src/sma_pkg.sv @@
// ---------------------------------------------------------------------------
// sma_pkg
// Types, codes and helpers of the swirl moment accumulator.
// ---------------------------------------------------------------------------
`default_nettype none

package sma_pkg;

   localparam int DIR_BITS   = 15;
   localparam int R_STEPS    = 15;
   localparam int MEAN_STEPS = 32;

   localparam logic [7:0] CSR_AXIS_X = 8'd0;
   localparam logic [7:0] CSR_AXIS_Y = 8'd1;
   localparam logic [7:0] CSR_AXIS_Z = 8'd2;
   localparam logic [7:0] CSR_DIR_X  = 8'd3;
   localparam logic [7:0] CSR_DIR_Y  = 8'd4;
   localparam logic [7:0] CSR_DIR_Z  = 8'd5;

   localparam logic signed [65:0] S32_MAX = 66'sd2147483647;
   localparam logic signed [65:0] S32_MIN = -66'sd2147483648;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] vel_z;
      logic [31:0]        cell_volume;
      logic [31:0]        density;
      logic               last_cell;
   } sma_req_type;

   typedef struct packed {
      logic [31:0]        mean_swirl;
      logic signed [63:0] swirl_sum;
      logic [62:0]        mass_sum;
      logic               zero_mass;
   } sma_rsp_type;

   // Controller states; each one is also the datapath micro-op.
   typedef enum logic [6:0] {
      OP_IDLE,
      OP_CD0, OP_CD1, OP_CD2, OP_CD3,
      OP_AD0, OP_AD1, OP_AD2, OP_AD3,
      OP_HH0, OP_HH1, OP_HH2, OP_HH3,
      OP_SQ_GO, OP_SQ_WAIT,
      OP_R_GO, OP_R_WAIT, OP_R_PUT,
      OP_T0, OP_T1, OP_T2, OP_T3, OP_T4, OP_T5, OP_T6,
      OP_VT0, OP_VT1, OP_VT2, OP_VT3,
      OP_TV0, OP_TV1, OP_TV2, OP_TV3,
      OP_M0, OP_M1, OP_M2, OP_M3, OP_M4, OP_M5, OP_M6,
      OP_S0, OP_S1, OP_S2, OP_S3,
      OP_X1, OP_X2, OP_X3,
      OP_W, OP_PS,
      OP_B0, OP_B1, OP_B2, OP_B3, OP_B4,
      OP_TERM, OP_ACC,
      OP_MN0, OP_MN_GO, OP_MN_WAIT, OP_MN_OUT
   } sma_op_type;

   typedef struct packed {
      sma_op_type op;
      logic       load;
      logic [1:0] ridx;
   } sma_cmd_type;

   typedef struct packed {
      logic sq_busy;
      logic div_busy;
      logic last;
      logic need_div;
      logic out_free;
   } sma_sts_type;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
      if (x > S32_MAX) return 32'sh7fffffff;
      if (x < S32_MIN) return 32'sh80000000;
      return x[31:0];
   endfunction

endpackage

`default_nettype wire

@@ src/sma_sqrt.sv @@
// ---------------------------------------------------------------------------
// sma_sqrt
// Bit-pair integer square root of a 64-bit value, one bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module sma_sqrt (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] radicand,
   output logic             busy,
   output logic [31:0]      root
);

   logic        busy_ff, busy_in;
   logic [63:0] x_ff, x_in;
   logic [63:0] res_ff, res_in;
   logic [63:0] bit_ff, bit_in;
   logic [64:0] trial;

   always_comb begin
      trial   = {1'b0, res_ff} + {1'b0, bit_ff};
      busy_in = busy_ff;
      x_in    = x_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      if (start) begin
         busy_in = 1'b1;
         x_in    = radicand;
         res_in  = '0;
         bit_in  = 64'h4000_0000_0000_0000;
      end else if (busy_ff) begin
         if ({1'b0, x_ff} >= trial) begin
            x_in   = x_ff - trial[63:0];
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff[0]) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      x_ff   <= x_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   assign busy = busy_ff;
   assign root = res_ff[31:0];

endmodule

`default_nettype wire

@@ src/sma_div.sv @@
// ---------------------------------------------------------------------------
// sma_div
// Restoring divider, one quotient bit per cycle, up to 32 bits.
// ---------------------------------------------------------------------------
`default_nettype none

module sma_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] rem_init,   // upper part of dividend, below divisor
   input  wire logic [31:0] low_bits,   // dividend bits shifted in, msb first
   input  wire logic [63:0] divisor,
   input  wire logic [5:0]  steps,
   output logic             busy,
   output logic [31:0]      quotient
);

   logic        busy_ff, busy_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [63:0] rem_ff, rem_in;
   logic [31:0] low_ff, low_in;
   logic [63:0] dvs_ff, dvs_in;
   logic [31:0] quo_ff, quo_in;
   logic [64:0] trial;

   always_comb begin
      trial   = {rem_ff, low_ff[31]};
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      low_in  = low_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = steps;
         rem_in  = rem_init;
         low_in  = low_bits;
         dvs_in  = divisor;
         quo_in  = '0;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = 64'(trial - {1'b0, dvs_ff});
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = trial[63:0];
            quo_in = {quo_ff[30:0], 1'b0};
         end
         low_in = {low_ff[30:0], 1'b0};
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      low_ff <= low_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

@@ src/sma_ctrl.sv @@
// ---------------------------------------------------------------------------
// sma_ctrl
// Sequencer: steps the datapath through one cell's micro-ops.
// ---------------------------------------------------------------------------
`default_nettype none

module sma_ctrl
   import sma_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire sma_sts_type sts,
   output sma_cmd_type      cmd
);

   sma_op_type state_ff, state_in;
   logic [1:0] ridx_ff, ridx_in;

   // next state
   always_comb begin
      state_in = sma_op_type'(state_ff + 7'd1);
      ridx_in  = ridx_ff;
      case (state_ff)
         OP_IDLE: begin
            ridx_in  = '0;
            state_in = req_valid ? OP_CD0 : OP_IDLE;
         end
         OP_SQ_WAIT: state_in = sts.sq_busy ? OP_SQ_WAIT : OP_R_GO;
         OP_R_WAIT:  state_in = sts.div_busy ? OP_R_WAIT : OP_R_PUT;
         OP_R_PUT: begin
            ridx_in  = ridx_ff + 2'd1;
            state_in = (ridx_ff == 2'd2) ? OP_T0 : OP_R_GO;
         end
         OP_ACC:     state_in = sts.last ? OP_MN0 : OP_IDLE;
         OP_MN_GO:   state_in = sts.need_div ? OP_MN_WAIT : OP_MN_OUT;
         OP_MN_WAIT: state_in = sts.div_busy ? OP_MN_WAIT : OP_MN_OUT;
         OP_MN_OUT:  state_in = sts.out_free ? OP_IDLE : OP_MN_OUT;
         default: ;
      endcase
   end

   // outputs
   always_comb begin
      req_ready = 1'b0;
      cmd.op    = state_ff;
      cmd.ridx  = ridx_ff;
      cmd.load  = 1'b0;
      case (state_ff)
         OP_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= OP_IDLE;
         ridx_ff  <= '0;
      end else begin
         state_ff <= state_in;
         ridx_ff  <= ridx_in;
      end
   end

endmodule

`default_nettype wire

@@ src/sma_datapath.sv @@
// ---------------------------------------------------------------------------
// sma_datapath
// Shared 33x33 multiplier, operand registers, accumulators, config, output.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sma_datapath
   import sma_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire sma_cmd_type cmd,
   output sma_sts_type      sts,
   input  wire sma_req_type req_payload,
   input  wire logic        csr_valid,
   input  wire logic [7:0]  csr_index,
   input  wire logic [31:0] csr_wdata,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output sma_rsp_type      rsp_payload
);

   localparam int SAT_SHIFT = 32 - FRAC_BITS;

   logic signed [31:0] axis_ff [3];
   logic signed [15:0] dir_ff  [3];

   logic signed [31:0] c_ff [3];
   logic signed [31:0] v_ff [3];
   logic signed [31:0] h_ff [3];
   logic signed [15:0] r_ff [3];
   logic signed [16:0] t_ff [3];
   logic signed [31:0] tv_ff [3];
   logic signed [31:0] m_ff [3];
   logic signed [31:0] a_ff, vt_ff, s_ff, ax_ff;
   logic [31:0]        vol_ff, dens_ff;
   logic               last_ff;
   logic signed [63:0] acc_ff;
   logic [63:0]        w_ff;
   logic [62:0]        pm_ff;
   logic               pneg_ff;
   logic [127:0]       big_ff;
   logic signed [63:0] term_ff;
   logic signed [63:0] swirl_ff;
   logic [62:0]        mass_ff;
   logic [63:0]        mag_ff;
   logic               zero_ff, satm_ff;
   logic               rsp_valid_ff;
   sma_rsp_type        rsp_ff;

   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] prod_ff;
   logic signed [65:0] sum_p, diff_p, shf_p;

   logic               sq_start, sq_busy;
   logic [31:0]        sq_root;
   logic               dv_start, dv_busy;
   logic [63:0]        dv_rem, dv_dvs;
   logic [31:0]        dv_low, dv_quo;
   logic [5:0]         dv_steps;

   logic [31:0]        habs;
   logic [15:0]        rq;
   logic [127:0]       big_sh;
   logic [63:0]        lim, term_mag;
   logic signed [64:0] swirl_sum;
   logic [64:0]        mass_sum;
   logic               need_div;

   function automatic logic signed [32:0] s32(input logic signed [31:0] x);
      return {x[31], x};
   endfunction

   function automatic logic signed [32:0] s16(input logic signed [15:0] x);
      return {{17{x[15]}}, x};
   endfunction

   function automatic logic signed [32:0] s17(input logic signed [16:0] x);
      return {{16{x[16]}}, x};
   endfunction

   function automatic logic signed [32:0] u32(input logic [31:0] x);
      return {1'b0, x};
   endfunction

   // operand select for the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         OP_CD0: begin mul_a = s32(c_ff[0]); mul_b = s16(dir_ff[0]); end
         OP_CD1: begin mul_a = s32(c_ff[1]); mul_b = s16(dir_ff[1]); end
         OP_CD2: begin mul_a = s32(c_ff[2]); mul_b = s16(dir_ff[2]); end
         OP_AD0: begin mul_a = s32(a_ff); mul_b = s16(dir_ff[0]); end
         OP_AD1: begin mul_a = s32(a_ff); mul_b = s16(dir_ff[1]); end
         OP_AD2: begin mul_a = s32(a_ff); mul_b = s16(dir_ff[2]); end
         OP_HH0: begin mul_a = s32(h_ff[0]); mul_b = s32(h_ff[0]); end
         OP_HH1: begin mul_a = s32(h_ff[1]); mul_b = s32(h_ff[1]); end
         OP_HH2: begin mul_a = s32(h_ff[2]); mul_b = s32(h_ff[2]); end
         OP_T0:  begin mul_a = s16(dir_ff[1]); mul_b = s16(r_ff[2]); end
         OP_T1:  begin mul_a = s16(dir_ff[2]); mul_b = s16(r_ff[1]); end
         OP_T2:  begin mul_a = s16(dir_ff[2]); mul_b = s16(r_ff[0]); end
         OP_T3:  begin mul_a = s16(dir_ff[0]); mul_b = s16(r_ff[2]); end
         OP_T4:  begin mul_a = s16(dir_ff[0]); mul_b = s16(r_ff[1]); end
         OP_T5:  begin mul_a = s16(dir_ff[1]); mul_b = s16(r_ff[0]); end
         OP_VT0: begin mul_a = s32(v_ff[0]); mul_b = s17(t_ff[0]); end
         OP_VT1: begin mul_a = s32(v_ff[1]); mul_b = s17(t_ff[1]); end
         OP_VT2: begin mul_a = s32(v_ff[2]); mul_b = s17(t_ff[2]); end
         OP_TV0: begin mul_a = s32(vt_ff); mul_b = s17(t_ff[0]); end
         OP_TV1: begin mul_a = s32(vt_ff); mul_b = s17(t_ff[1]); end
         OP_TV2: begin mul_a = s32(vt_ff); mul_b = s17(t_ff[2]); end
         OP_M0:  begin mul_a = s32(h_ff[1]); mul_b = s32(tv_ff[2]); end
         OP_M1:  begin mul_a = s32(h_ff[2]); mul_b = s32(tv_ff[1]); end
         OP_M2:  begin mul_a = s32(h_ff[2]); mul_b = s32(tv_ff[0]); end
         OP_M3:  begin mul_a = s32(h_ff[0]); mul_b = s32(tv_ff[2]); end
         OP_M4:  begin mul_a = s32(h_ff[0]); mul_b = s32(tv_ff[1]); end
         OP_M5:  begin mul_a = s32(h_ff[1]); mul_b = s32(tv_ff[0]); end
         OP_S0:  begin mul_a = s32(m_ff[0]); mul_b = s16(dir_ff[0]); end
         OP_S1:  begin mul_a = s32(m_ff[1]); mul_b = s16(dir_ff[1]); end
         OP_S2:  begin mul_a = s32(m_ff[2]); mul_b = s16(dir_ff[2]); end
         OP_S3:  begin mul_a = s32(v_ff[0]); mul_b = s16(dir_ff[0]); end
         OP_X1:  begin mul_a = s32(v_ff[1]); mul_b = s16(dir_ff[1]); end
         OP_X2:  begin mul_a = s32(v_ff[2]); mul_b = s16(dir_ff[2]); end
         OP_X3:  begin mul_a = u32(vol_ff); mul_b = u32(dens_ff); end
         OP_W:   begin mul_a = s32(ax_ff); mul_b = s32(s_ff); end
         OP_B0:  begin mul_a = u32(pm_ff[31:0]); mul_b = u32(w_ff[31:0]); end
         OP_B1:  begin mul_a = u32(pm_ff[31:0]); mul_b = u32(w_ff[63:32]); end
         OP_B2:  begin mul_a = u32({1'b0, pm_ff[62:32]}); mul_b = u32(w_ff[31:0]); end
         OP_B3:  begin mul_a = u32({1'b0, pm_ff[62:32]}); mul_b = u32(w_ff[63:32]); end
         default: ;
      endcase
   end

   always_comb begin
      sum_p  = 66'(acc_ff) + prod_ff;
      diff_p = 66'(acc_ff) - prod_ff;
      shf_p  = prod_ff >>> FRAC_BITS;
      habs   = h_ff[cmd.ridx][31] ? 32'(-h_ff[cmd.ridx]) : 32'(h_ff[cmd.ridx]);
      rq     = {1'b0, dv_quo[R_STEPS-1:0]};
      // swirl term: |ax*s| * w / 2^(2F), clamped
      big_sh   = big_ff >> (2 * FRAC_BITS);
      lim      = pneg_ff ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
      term_mag = (big_sh > {64'd0, lim}) ? lim : big_sh[63:0];
      swirl_sum = 65'(swirl_ff) + 65'(term_ff);
      mass_sum  = {2'b00, mass_ff} + {1'b0, w_ff};
      need_div  = !zero_ff && !satm_ff;
   end

   // iterative units
   always_comb begin
      sq_start = (cmd.op == OP_SQ_GO);
      dv_start = 1'b0;
      dv_rem   = {32'd0, habs};
      dv_low   = '0;
      dv_dvs   = {31'd0, {1'b0, sq_root} + 33'd1};
      dv_steps = 6'(R_STEPS);
      case (cmd.op)
         OP_R_GO: dv_start = 1'b1;
         OP_MN_GO: begin
            dv_start = need_div;
            dv_rem   = mag_ff >> SAT_SHIFT;
            dv_low   = 32'(mag_ff << FRAC_BITS);
            dv_dvs   = {1'b0, mass_ff};
            dv_steps = 6'(MEAN_STEPS);
         end
         default: ;
      endcase
   end

   sma_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (acc_ff),
      .busy     (sq_busy),
      .root     (sq_root)
   );

   sma_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (dv_start),
      .rem_init (dv_rem),
      .low_bits (dv_low),
      .divisor  (dv_dvs),
      .steps    (dv_steps),
      .busy     (dv_busy),
      .quotient (dv_quo)
   );

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         axis_ff[0] <= '0;
         axis_ff[1] <= '0;
         axis_ff[2] <= '0;
         dir_ff[0]  <= '0;
         dir_ff[1]  <= 16'sd32767;
         dir_ff[2]  <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_AXIS_X: axis_ff[0] <= csr_wdata;
            CSR_AXIS_Y: axis_ff[1] <= csr_wdata;
            CSR_AXIS_Z: axis_ff[2] <= csr_wdata;
            CSR_DIR_X:  dir_ff[0]  <= csr_wdata[15:0];
            CSR_DIR_Y:  dir_ff[1]  <= csr_wdata[15:0];
            CSR_DIR_Z:  dir_ff[2]  <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      if (cmd.load) begin
         c_ff[0] <= sat32(66'(req_payload.pos_x) - 66'(axis_ff[0]));
         c_ff[1] <= sat32(66'(req_payload.pos_y) - 66'(axis_ff[1]));
         c_ff[2] <= sat32(66'(req_payload.pos_z) - 66'(axis_ff[2]));
         v_ff[0] <= req_payload.vel_x;
         v_ff[1] <= req_payload.vel_y;
         v_ff[2] <= req_payload.vel_z;
         vol_ff  <= req_payload.cell_volume;
         dens_ff <= req_payload.density;
         last_ff <= req_payload.last_cell;
      end
      case (cmd.op)
         OP_CD1, OP_HH1, OP_T1, OP_T3, OP_T5, OP_VT1, OP_S1, OP_X1:
            acc_ff <= prod_ff[63:0];
         OP_CD2, OP_HH2, OP_HH3, OP_VT2, OP_S2, OP_X2:
            acc_ff <= acc_ff + prod_ff[63:0];
         OP_CD3: a_ff <= sat32(sum_p >>> DIR_BITS);
         OP_AD1: h_ff[0] <= sat32(66'(c_ff[0]) - (prod_ff >>> DIR_BITS));
         OP_AD2: h_ff[1] <= sat32(66'(c_ff[1]) - (prod_ff >>> DIR_BITS));
         OP_AD3: h_ff[2] <= sat32(66'(c_ff[2]) - (prod_ff >>> DIR_BITS));
         OP_R_PUT: r_ff[cmd.ridx] <= h_ff[cmd.ridx][31] ? 16'(-rq) : rq;
         OP_T2: t_ff[0] <= 17'(diff_p >>> DIR_BITS);
         OP_T4: t_ff[1] <= 17'(diff_p >>> DIR_BITS);
         OP_T6: t_ff[2] <= 17'(diff_p >>> DIR_BITS);
         OP_VT3: vt_ff <= sat32(sum_p >>> DIR_BITS);
         OP_TV1: tv_ff[0] <= sat32(prod_ff >>> DIR_BITS);
         OP_TV2: tv_ff[1] <= sat32(prod_ff >>> DIR_BITS);
         OP_TV3: tv_ff[2] <= sat32(prod_ff >>> DIR_BITS);
         OP_M1, OP_M3, OP_M5: acc_ff <= 64'(shf_p);
         OP_M2: m_ff[0] <= sat32(66'(acc_ff) - shf_p);
         OP_M4: m_ff[1] <= sat32(66'(acc_ff) - shf_p);
         OP_M6: m_ff[2] <= sat32(66'(acc_ff) - shf_p);
         OP_S3: s_ff <= sat32(sum_p >>> DIR_BITS);
         OP_X3: ax_ff <= sat32(sum_p >>> DIR_BITS);
         OP_W: w_ff <= prod_ff[63:0];
         OP_PS: begin
            pneg_ff <= prod_ff[65];
            pm_ff   <= prod_ff[65] ? 63'(-prod_ff) : prod_ff[62:0];
         end
         OP_B1: big_ff <= {64'd0, prod_ff[63:0]};
         OP_B2, OP_B3: big_ff <= big_ff + ({64'd0, prod_ff[63:0]} << 32);
         OP_B4: big_ff <= big_ff + ({64'd0, prod_ff[63:0]} << 64);
         OP_TERM: term_ff <= pneg_ff ? -term_mag : term_mag;
         OP_MN0: begin
            zero_ff <= (mass_ff == '0);
            mag_ff  <= swirl_ff[63] ? 64'(-swirl_ff) : 64'(swirl_ff);
            satm_ff <= ({32'd0, (swirl_ff[63] ? 64'(-swirl_ff) : 64'(swirl_ff))}
                        >= ({33'd0, mass_ff} << SAT_SHIFT));
         end
         default: ;
      endcase
   end

   // accumulators and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         swirl_ff     <= '0;
         mass_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         case (cmd.op)
            OP_ACC: begin
               if (swirl_sum > 65'sh0_7fff_ffff_ffff_ffff)
                  swirl_ff <= 64'sh7fff_ffff_ffff_ffff;
               else if (swirl_sum < -65'sh0_8000_0000_0000_0000)
                  swirl_ff <= 64'sh8000_0000_0000_0000;
               else
                  swirl_ff <= swirl_sum[63:0];
               mass_ff <= (mass_sum > {2'b00, {63{1'b1}}}) ? {63{1'b1}} : mass_sum[62:0];
            end
            OP_MN_OUT: begin
               if (!rsp_valid_ff) begin
                  rsp_valid_ff <= 1'b1;
                  swirl_ff     <= '0;
                  mass_ff      <= '0;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_MN_OUT && !rsp_valid_ff) begin
         rsp_ff.mean_swirl <= zero_ff ? 32'd0 : (satm_ff ? 32'hffff_ffff : dv_quo);
         rsp_ff.swirl_sum  <= swirl_ff;
         rsp_ff.mass_sum   <= mass_ff;
         rsp_ff.zero_mass  <= zero_ff;
      end
   end

   assign sts.sq_busy  = sq_busy;
   assign sts.div_busy = dv_busy;
   assign sts.last     = last_ff;
   assign sts.need_div = need_div;
   assign sts.out_free = !rsp_valid_ff;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `ASSERT_IMPLIES(a_sqrt_idle_on_start, clock, reset, sq_start, !sq_busy,
      "square root restarted while busy")
   `ASSERT_IMPLIES(a_div_idle_on_start, clock, reset, dv_start, !dv_busy,
      "divider restarted while busy")
   `ASSERT_IMPLIES(a_rsp_from_out_step, clock, reset, $rose(rsp_valid_ff),
      $past(cmd.op) == OP_MN_OUT, "result raised outside output step")
   `ASSERT_IMPLIES(a_zero_mass_mean, clock, reset, rsp_valid_ff && rsp_ff.zero_mass,
      rsp_ff.mean_swirl == 32'd0, "zero mass with nonzero mean")

endmodule

`default_nettype wire

@@ src/swirl_moment_accumulator_core.sv @@
// ---------------------------------------------------------------------------
// swirl_moment_accumulator_core
// Streams mesh cells and accumulates their swirl moment and mass.
// ---------------------------------------------------------------------------
// Usage:
//  - req_*: one beat per cell (centre, velocity, volume, density, last flag).
//    A beat is taken only while the core is idle; each cell then runs
//    through the square root, the three 15-bit radial divides and the
//    steps on the shared multiplier before the core is ready again.
//  - rsp_*: one beat after each cell flagged last_cell, carrying the
//    mean swirl, both sums and the zero-mass flag. The last cell adds
//    the mean divide (32 quotient bits) when one is needed, before
//    rsp_valid rises.
//  - csr_*: register writes, always ready; write only while idle.
//    Index 0..2 axis point, 3..5 swirl direction; other indexes ignored.
//  - Reset (synchronous, active high) clears the sums, the config to
//    its defaults (direction +y) and drops rsp_valid.
//  - A stalled receiver holds the result in the output register; the
//    next cell is still accepted and processed, but the next result
//    waits, holding off further cells, until the pending one is taken.
// ---------------------------------------------------------------------------
`default_nettype none

module swirl_moment_accumulator_core
   import sma_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire sma_req_type req_payload,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output sma_rsp_type      rsp_payload,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [7:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);

   sma_cmd_type cmd;
   sma_sts_type sts;

   // config writes are always accepted and land in the next cycle
   assign csr_ready = 1'b1;

   sma_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   sma_datapath #(
      .FRAC_BITS (FRAC_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_payload (req_payload),
      .csr_valid   (csr_valid),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

@@ test/swirl_checker.sv @@
// ---------------------------------------------------------------------------
// swirl_checker
// Watches the cell, result and register channels of the swirl moment
// accumulator, predicts each result beat and compares it field by field.
// ---------------------------------------------------------------------------
`default_nettype none

module swirl_checker
   import sma_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_ready,
   input  wire sma_req_type req_payload,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_ready,
   input  wire sma_rsp_type rsp_payload,
   input  wire logic        csr_valid,
   input  wire logic        csr_ready,
   input  wire logic [7:0]  csr_index,
   input  wire logic [31:0] csr_wdata,
   output int               fail_count,
   output int               pending_count,
   output int               result_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint unsigned MASS_LIMIT = 64'h7fff_ffff_ffff_ffff;

   longint          pt_x, pt_y, pt_z;
   longint          ax_dx, ax_dy, ax_dz;
   longint          swirl_total;
   longint unsigned mass_total;
   sma_rsp_type     result_queue[$];

   function automatic longint clamp_s32(input longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
   endfunction

   function automatic longint unsigned int_root(input longint unsigned x);
      longint unsigned res;
      longint unsigned bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (x >= res + bitv) begin
            x = x - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // adds one cell to the sums; returns 1 with the result beat on a last cell
   function automatic bit add_cell(input sma_req_type mesh_cell, output sma_rsp_type beat);
      longint          d[3], c[3], h[3], r[3], t[3], v[3], tv[3], m[3];
      longint          a, vt, s, axv, prod, term;
      longint unsigned sq, root_len, w, ua, mag, lim;
      logic [127:0]    wide;
      logic signed [64:0] sum65;
      d[0] = ax_dx; d[1] = ax_dy; d[2] = ax_dz;
      c[0] = clamp_s32(longint'(mesh_cell.pos_x) - pt_x);
      c[1] = clamp_s32(longint'(mesh_cell.pos_y) - pt_y);
      c[2] = clamp_s32(longint'(mesh_cell.pos_z) - pt_z);
      v[0] = longint'(mesh_cell.vel_x);
      v[1] = longint'(mesh_cell.vel_y);
      v[2] = longint'(mesh_cell.vel_z);
      a = clamp_s32((c[0] * d[0] + c[1] * d[1] + c[2] * d[2]) >>> DIR_BITS);
      sq = 0;
      for (int i = 0; i < 3; i++) begin
         h[i] = clamp_s32(c[i] - ((a * d[i]) >>> DIR_BITS));
         sq = sq + longint'(h[i] * h[i]);
      end
      root_len = int_root(sq);
      // one LSB epsilon keeps the divide defined on the axis
      for (int i = 0; i < 3; i++) r[i] = (h[i] * 32768) / (longint'(root_len) + 1);
      t[0] = (d[1] * r[2] - d[2] * r[1]) >>> DIR_BITS;
      t[1] = (d[2] * r[0] - d[0] * r[2]) >>> DIR_BITS;
      t[2] = (d[0] * r[1] - d[1] * r[0]) >>> DIR_BITS;
      vt = clamp_s32((v[0] * t[0] + v[1] * t[1] + v[2] * t[2]) >>> DIR_BITS);
      for (int i = 0; i < 3; i++) tv[i] = clamp_s32((vt * t[i]) >>> DIR_BITS);
      m[0] = clamp_s32(((h[1] * tv[2]) >>> FRAC_BITS) - ((h[2] * tv[1]) >>> FRAC_BITS));
      m[1] = clamp_s32(((h[2] * tv[0]) >>> FRAC_BITS) - ((h[0] * tv[2]) >>> FRAC_BITS));
      m[2] = clamp_s32(((h[0] * tv[1]) >>> FRAC_BITS) - ((h[1] * tv[0]) >>> FRAC_BITS));
      s = clamp_s32((m[0] * d[0] + m[1] * d[1] + m[2] * d[2]) >>> DIR_BITS);
      axv = clamp_s32((v[0] * d[0] + v[1] * d[1] + v[2] * d[2]) >>> DIR_BITS);
      w = longint'(mesh_cell.cell_volume) * longint'(mesh_cell.density);
      // swirl term: magnitude product, truncate toward zero, saturate
      prod = axv * s;
      ua = (prod < 0) ? -prod : prod;
      wide = (128'(ua) * 128'(w)) >> (2 * FRAC_BITS);
      lim = (prod < 0) ? 64'h8000_0000_0000_0000 : MASS_LIMIT;
      mag = (wide > 128'(lim)) ? lim : wide[63:0];
      term = (prod < 0) ? -longint'(mag) : longint'(mag);
      sum65 = 65'(swirl_total) + 65'(term);
      if (sum65 > 65'sh0_7fff_ffff_ffff_ffff) swirl_total = 64'sh7fff_ffff_ffff_ffff;
      else if (sum65 < -65'sh0_8000_0000_0000_0000) swirl_total = 64'sh8000_0000_0000_0000;
      else swirl_total = sum65[63:0];
      if (w > MASS_LIMIT - mass_total) mass_total = MASS_LIMIT;
      else mass_total = mass_total + w;
      if (!mesh_cell.last_cell) return 0;
      beat.mean_swirl = '0;
      if (mass_total != 0) begin
         mag = (swirl_total < 0) ? -swirl_total : swirl_total;
         if (mag / mass_total >= (64'd1 << (32 - FRAC_BITS)))
            beat.mean_swirl = 32'hffff_ffff;
         else
            beat.mean_swirl = 32'((128'(mag) << FRAC_BITS) / 128'(mass_total));
      end
      beat.swirl_sum = swirl_total;
      beat.mass_sum  = mass_total[62:0];
      beat.zero_mass = (mass_total == 0);
      swirl_total = 0;
      mass_total  = 0;
      return 1;
   endfunction

   always @(posedge clock) begin
      sma_rsp_type want;
      sma_rsp_type got;
      if (reset) begin
         pt_x <= 0; pt_y <= 0; pt_z <= 0;
         ax_dx <= 0; ax_dy <= 32767; ax_dz <= 0;
         swirl_total = 0;
         mass_total = 0;
         result_queue.delete();
         fail_count = 0;
         result_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_AXIS_X: pt_x <= longint'($signed(csr_wdata));
               CSR_AXIS_Y: pt_y <= longint'($signed(csr_wdata));
               CSR_AXIS_Z: pt_z <= longint'($signed(csr_wdata));
               CSR_DIR_X:  ax_dx <= longint'($signed(csr_wdata[15:0]));
               CSR_DIR_Y:  ax_dy <= longint'($signed(csr_wdata[15:0]));
               CSR_DIR_Z:  ax_dz <= longint'($signed(csr_wdata[15:0]));
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            if (add_cell(req_payload, want)) result_queue.push_back(want);
         end
         if (rsp_valid && rsp_ready) begin
            got = rsp_payload;
            result_count++;
            if (result_queue.size() == 0) begin
               fail_count++;
               $display("%0t: result beat with none expected: %p", $time, got);
            end else begin
               want = result_queue.pop_front();
               if (got.mean_swirl !== want.mean_swirl) begin
                  fail_count++;
                  $display("%0t: mean_swirl expected %h got %h", $time,
                           want.mean_swirl, got.mean_swirl);
               end
               if (got.swirl_sum !== want.swirl_sum) begin
                  fail_count++;
                  $display("%0t: swirl_sum expected %h got %h", $time,
                           want.swirl_sum, got.swirl_sum);
               end
               if (got.mass_sum !== want.mass_sum) begin
                  fail_count++;
                  $display("%0t: mass_sum expected %h got %h", $time,
                           want.mass_sum, got.mass_sum);
               end
               if (got.zero_mass !== want.zero_mass) begin
                  fail_count++;
                  $display("%0t: zero_mass expected %b got %b", $time,
                           want.zero_mass, got.zero_mass);
               end
            end
         end
      end
      pending_count = result_queue.size();
   end

endmodule

`default_nettype wire

@@ test/testbench.sv @@
// ---------------------------------------------------------------------------
// testbench
// Drives cells and register writes into the swirl moment accumulator
// under varying sender and receiver stalls; the checker predicts results.
// ---------------------------------------------------------------------------
`default_nettype none

module testbench
   import sma_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 1_500_000;
   // a cell with no result may still be in flight: its micro-ops plus mean divide
   localparam int SETTLE      = 250;
   localparam int PHASE_CELLS = 530;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   sma_req_type req_payload = '0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   sma_rsp_type rsp_payload;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [7:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   int fail_count, pending_count, result_count;
   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   int cycles = 0;
   int cells_sent = 0;
   bit hold_go = 0;
   bit hold_done = 0;

   always #5 clock = ~clock;

   swirl_moment_accumulator_core DUT (
      .clock, .reset, .req_valid, .req_ready, .req_payload,
      .rsp_valid, .rsp_ready, .rsp_payload,
      .csr_valid, .csr_ready, .csr_index, .csr_wdata
   );

   swirl_checker chk (
      .clock, .reset, .req_valid, .req_ready, .req_payload,
      .rsp_valid, .rsp_ready, .rsp_payload,
      .csr_valid, .csr_ready, .csr_index, .csr_wdata,
      .fail_count, .pending_count, .result_count
   );

   // long receiver hold-off, counted here so the main thread keeps sending
   initial begin
      wait (hold_go);
      repeat (1500) @(posedge clock);
      hold_done = 1;
   end

   // receiver: random stalls, or none at all while rx_idle_pct is zero
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_go && !hold_done) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycles);
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic write_reg(input logic [7:0] idx, input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // wait until the checker has seen every expected result
   task automatic wait_results();
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   // all results in, then room for a cell that makes none
   task automatic drain();
      wait_results();
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_axis(input logic [31:0] px, py, pz, input logic [15:0] dx, dy, dz);
      drain();
      write_reg(CSR_AXIS_X, px);
      write_reg(CSR_AXIS_Y, py);
      write_reg(CSR_AXIS_Z, pz);
      write_reg(CSR_DIR_X, {{16{dx[15]}}, dx});
      write_reg(CSR_DIR_Y, {{16{dy[15]}}, dy});
      write_reg(CSR_DIR_Z, {{16{dz[15]}}, dz});
   endtask

   // one cell beat; valid stays up across back-to-back beats
   task automatic send_cell(input sma_req_type mesh_cell);
      req_valid   <= 1'b1;
      req_payload <= mesh_cell;
      do @(posedge clock); while (!req_ready);
      cells_sent++;
      if ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   function automatic logic [31:0] pick_coord();
      case ($urandom_range(9))
         0: case ($urandom_range(3))
               0: return 32'h7fff_ffff;
               1: return 32'h8000_0000;
               2: return 32'h0;
               default: return 32'hffff_ffff;
            endcase
         1, 2: return $urandom;
         default: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
      endcase
   endfunction

   function automatic logic [31:0] pick_amount();
      case ($urandom_range(9))
         0: return 32'h0;
         1: return $urandom;
         2: return 32'hffff_ffff;
         default: return $urandom_range(0, 32'h0004_0000);
      endcase
   endfunction

   function automatic sma_req_type rand_cell(input logic last);
      sma_req_type mesh_cell;
      mesh_cell.pos_x = pick_coord();
      mesh_cell.pos_y = pick_coord();
      mesh_cell.pos_z = pick_coord();
      mesh_cell.vel_x = pick_coord();
      mesh_cell.vel_y = pick_coord();
      mesh_cell.vel_z = pick_coord();
      mesh_cell.cell_volume = pick_amount();
      mesh_cell.density = pick_amount();
      mesh_cell.last_cell = last;
      return mesh_cell;
   endfunction

   function automatic sma_req_type make_cell(input logic [31:0] px, py, pz, vx, vy, vz,
                                             input logic [31:0] vol, den,
                                             input logic last);
      sma_req_type mesh_cell;
      mesh_cell = '{px, py, pz, vx, vy, vz, vol, den, last};
      return mesh_cell;
   endfunction

   // random zones: groups of cells closed by a last cell
   task automatic send_zones(input int count, input bit pause_midway);
      int n;
      int group;
      n = 0;
      while (n < count) begin
         group = $urandom_range(1, 6);
         for (int k = 0; k < group && n < count; k++) begin
            send_cell(rand_cell(k == group - 1 || n == count - 1));
            n++;
         end
         if (pause_midway && n >= count / 2) begin
            pause_midway = 0;
            req_valid <= 1'b0;
            wait_results();
         end
      end
      req_valid <= 1'b0;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed cells on the reset axis (origin, +y), no stalls
      send_cell(make_cell(0, 32'h0005_0000, 0, 32'h0001_0000, 32'h0002_0000, 0,
                          32'h0001_0000, 32'h0001_0000, 1));         // on the axis
      send_cell(make_cell(32'h0001_0000, 0, 0, 0, 32'h0001_0000, 32'h0001_0000,
                          32'h0001_0000, 32'h0002_0000, 0));
      send_cell(make_cell(0, 0, 32'h0002_0000, 32'h0001_0000, 32'h0003_0000, 0,
                          32'h0000_8000, 32'h0001_0000, 1));
      send_cell(make_cell(32'h0001_0000, 0, 0, 32'h1234, 32'h0001_0000, 32'h0001_0000,
                          0, 32'h0001_0000, 1));                     // zero mass
      send_cell(make_cell(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                          32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'hffff_ffff, 0));
      send_cell(make_cell(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
                          32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1));
      for (int k = 0; k < 4; k++)                                    // swirl sum saturates
         send_cell(make_cell(32'h7fff_0000, 0, 32'h7fff_0000, 32'h8000_0000,
                             32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_ffff, 32'h7fff_ffff,
                             k == 3));
      send_cell(make_cell(32'h0100_0000, 0, 0, 0, 32'h7fff_ffff, 32'h7fff_ffff,
                          1, 1, 1));                                 // huge mean
      send_cell(make_cell(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                          32'hffff_ffff, 32'hffff_ffff, 1, 32'hffff_ffff, 1));
      send_cell(make_cell(0, 0, 0, 0, 0, 0, 0, 0, 1));
      req_valid <= 1'b0;

      // extreme axis and direction settings, plus two ignored indexes
      set_axis(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 16'h8000, 16'h8000, 16'h8000);
      write_reg(8'd6, 32'hdead_beef);
      write_reg(8'hff, 32'h1234_5678);
      send_cell(make_cell(32'h8000_0000, 32'h7fff_ffff, 0, 32'h0001_0000, 32'h8000_0000,
                          32'h7fff_ffff, 32'h0001_0000, 32'h0001_0000, 0));
      send_cell(make_cell(0, 0, 0, 32'h7fff_ffff, 32'h0001_0000, 32'h8000_0000,
                          32'h0002_0000, 32'h0001_0000, 1));
      req_valid <= 1'b0;
      set_axis(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 16'h7fff, 16'h7fff, 16'h7fff);
      send_cell(make_cell(0, 0, 0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                          32'h0001_0000, 32'h0001_0000, 1));
      req_valid <= 1'b0;

      // phase one: light sender idling, heavy receiver idling, long hold-off
      set_axis(32'h0001_0000, 32'hffff_0000, 0, 16'h7fff, 16'h0000, 16'h0000);
      tx_idle_pct = 17;
      rx_idle_pct = 66;
      hold_go = 1;
      send_zones(PHASE_CELLS, 1);

      // phase two: roles swapped, diagonal direction
      set_axis($urandom, $urandom, $urandom, 16'h5a82, 16'h5a82, 16'h0000);
      tx_idle_pct = 66;
      rx_idle_pct = 17;
      send_zones(PHASE_CELLS, 0);

      // phase three: full rate, random axis point, fixed non-unit direction, zero direction at the end
      set_axis($urandom_range(0, 32'h0010_0000), 0, $urandom, 16'h4000, 16'hc000, 16'h2000);
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      send_zones(PHASE_CELLS - 60, 1);
      set_axis(0, 0, 0, 16'h0000, 16'h0000, 16'h0000);
      send_zones(60, 0);

      drain();

      $display("Sent %0d cells, checked %0d results over 7 axis settings", cells_sent,
               result_count);
      $display("Stall mixes: 17/66, 66/17, none; one long output hold-off");
      if (fail_count == 0 && pending_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
